// ===== design/vcp_pkg.sv =====
package vcp_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   localparam logic [3:0] PORT_VRAM   = 4'd0;
   localparam logic [3:0] PORT_PAL    = 4'd1;
   localparam logic [3:0] PORT_CMD    = 4'd2;
   localparam logic [3:0] PORT_REGDAT = 4'd3;
   localparam logic [3:0] PORT_REGSEL = 4'd4;
   localparam logic [3:0] PORT_STATUS = 4'd5;
   localparam logic [3:0] PORT_IRQ    = 4'd6;
   localparam logic [3:0] PORT_SYSCTL = 4'd7;

   localparam logic [1:0] VACC_NONE  = 2'd0;
   localparam logic [1:0] VACC_READ  = 2'd1;
   localparam logic [1:0] VACC_WRITE = 2'd2;

   localparam logic [2:0] CACC_NONE  = 3'd0;
   localparam logic [2:0] CACC_PARAM = 3'd1;
   localparam logic [2:0] CACC_WDATA = 3'd2;
   localparam logic [2:0] CACC_RDATA = 3'd3;
   localparam logic [2:0] CACC_CLEAR = 3'd4;

   localparam int unsigned R_VWRITE  = 0;
   localparam int unsigned R_VREAD   = 3;
   localparam int unsigned R_IMASK   = 9;
   localparam int unsigned R_PALCTL  = 13;
   localparam int unsigned R_PALPTR  = 14;
   localparam logic [5:0] R_BORDER_LO = 6'd53;
   localparam logic [5:0] R_BORDER_HI = 6'd54;

   localparam int unsigned NUM_REGS = 32;
   localparam int unsigned PAL_DEPTH = 256;

   localparam logic [1:0] ACC_TAB [64] = '{
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd0, 2'd0, 2'd0,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
   };

   localparam logic [7:0] WMASK_TAB [32] = '{
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'h87, 8'hFF, 8'h83, 8'h0F, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hDF, 8'h07, 8'hFF, 8'hFF, 8'hC1, 8'h07,
      8'h3F, 8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   localparam logic [7:0] COMP_MASK [4] = '{8'h9F, 8'h1F, 8'h1F, 8'h00};

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } pal_wr_type;

endpackage

// ===== design/vcp_palette_ram.sv =====
module vcp_palette_ram (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        rd_addr,
   output logic [7:0]        rd_data,
   input  vcp_pkg::pal_wr_type wr
);
   import vcp_pkg::*;

   logic [7:0] mem [PAL_DEPTH];
   logic [PAL_DEPTH-1:0] valid_ff;
   logic [7:0] data_ff;
   logic       hit_ff;
   logic [1:0] comp_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      data_ff <= mem[rd_addr];
      hit_ff  <= valid_ff[rd_addr];
      comp_ff <= rd_addr[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // unwritten entries read as their reset value
   assign rd_data = hit_ff ? data_ff : COMP_MASK[comp_ff];

endmodule

// ===== design/video_chip_port_register_file_core.sv =====
// Request path: a request is accepted only while the block is idle; the palette
// memory is read at the accepting edge, then the execute state registers the response
// once the output is free. A new request is not accepted until the previous one commits.
// Reset: synchronous, active high; control registers, flags and select are
// set to their reset values at once, palette entries read as defaults.
module video_chip_port_register_file_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_port,
   input  logic [7:0]  req_wdata,
   input  logic [7:0]  req_vram_rdata,
   input  logic [7:0]  req_cmd_rdata,
   input  logic [7:0]  req_cmd_status,
   input  logic        req_in_hborder,
   input  logic        req_in_vborder,
   input  logic [15:0] req_border_x,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata,
   output logic [18:0] rsp_vram_addr,
   output logic [1:0]  rsp_vram_access,
   output logic [2:0]  rsp_cmd_access,
   output logic [5:0]  rsp_cmd_reg,
   output logic [7:0]  rsp_out_data,
   output logic        rsp_irq_line
);
   import vcp_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]  op_ff;
   logic [3:0]  port_ff;
   logic [7:0]  wd_ff, vrd_ff, crd_ff, cst_ff;
   logic        hb_ff, vb_ff;
   logic [15:0] bx_ff;

   logic [7:0] regs_ff [NUM_REGS];
   logic [7:0] regs_in [NUM_REGS];
   logic [7:0] sel_ff, sel_in;
   logic [7:0] pend_ff, pend_in;
   logic       eo_ov_ff, eo_ov_in;
   logic       srm_ff, srm_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [18:0] vaddr_ff, vaddr_in;
   logic [1:0]  vacc_ff, vacc_in;
   logic [2:0]  cacc_ff, cacc_in;
   logic [5:0]  creg_ff, creg_in;
   logic [7:0]  odata_ff, odata_in;
   logic        irq_ff, irq_in;

   logic [7:0] pal_rdata;
   pal_wr_type pal_wr;

   logic accept, commit;
   logic [18:0] vnext;
   logic [5:0]  ridx;
   logic [7:0]  wval;
   logic [7:0]  pptr;

   vcp_palette_ram u_pal (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (regs_ff[R_PALPTR]),
      .rd_data (pal_rdata),
      .wr      (pal_wr)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      regs_in      = regs_ff;
      sel_in       = sel_ff;
      pend_in      = pend_ff;
      eo_ov_in     = eo_ov_ff;
      srm_in       = srm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rdata_in     = rdata_ff;
      vaddr_in     = vaddr_ff;
      vacc_in      = vacc_ff;
      cacc_in      = cacc_ff;
      creg_in      = creg_ff;
      odata_in     = odata_ff;
      irq_in       = irq_ff;
      pal_wr       = '0;
      vnext        = '0;
      ridx         = sel_ff[5:0];
      wval         = srm_ff ? 8'h00 : wd_ff;
      pptr         = regs_ff[R_PALPTR];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rdata_in     = 8'h00;
               vaddr_in     = '0;
               vacc_in      = VACC_NONE;
               cacc_in      = CACC_NONE;
               creg_in      = '0;
               odata_in     = 8'h00;
               case (pptr[1:0])
                  2'd0, 2'd1: pptr = pptr + 8'd1;
                  2'd2:       pptr = pptr + 8'd2;
                  default:    pptr = pptr - 8'd3;
               endcase
               case (op_type'(op_ff))
                  OP_READ: begin
                     rdata_in = 8'hFF;
                     case (port_ff)
                        PORT_VRAM: begin
                           vaddr_in = {regs_ff[R_VREAD+2][2:0], regs_ff[R_VREAD+1],
                                       regs_ff[R_VREAD]};
                           vacc_in  = VACC_READ;
                           rdata_in = vrd_ff;
                           if (!srm_ff && !regs_ff[R_VREAD+2][7]) begin
                              vnext = vaddr_in + 19'd1;
                              regs_in[R_VREAD]   = vnext[7:0];
                              regs_in[R_VREAD+1] = vnext[15:8];
                              regs_in[R_VREAD+2] = {regs_ff[R_VREAD+2][7], 4'b0,
                                                    vnext[18:16]};
                           end
                        end
                        PORT_PAL: begin
                           rdata_in = pal_rdata;
                           if (!srm_ff && !regs_ff[R_PALCTL][4]) begin
                              regs_in[R_PALPTR] = pptr;
                           end
                        end
                        PORT_CMD: begin
                           rdata_in = crd_ff;
                           cacc_in  = CACC_RDATA;
                        end
                        PORT_REGDAT: begin
                           if (srm_ff || !ACC_TAB[ridx][0]) begin
                              rdata_in = 8'hFF;
                           end else if (ridx == R_BORDER_LO) begin
                              rdata_in = bx_ff[7:0];
                           end else if (ridx == R_BORDER_HI) begin
                              rdata_in = bx_ff[15:8];
                           end else begin
                              rdata_in = regs_ff[ridx[4:0]];
                           end
                           if (!srm_ff && !sel_ff[6]) begin
                              sel_in = (sel_ff + 8'd1) & 8'hBF;
                           end
                        end
                        PORT_STATUS: begin
                           rdata_in = cst_ff | {1'b0, vb_ff, hb_ff, 2'b0, eo_ov_ff, 2'b0};
                        end
                        PORT_IRQ: begin
                           rdata_in = pend_ff;
                        end
                        default: begin
                           rdata_in = 8'hFF;
                        end
                     endcase
                  end
                  OP_WRITE: begin
                     case (port_ff)
                        PORT_VRAM: begin
                           if (!srm_ff) begin
                              vaddr_in = {regs_ff[R_VWRITE+2][2:0], regs_ff[R_VWRITE+1],
                                          regs_ff[R_VWRITE]};
                              vacc_in  = VACC_WRITE;
                              odata_in = wd_ff;
                              if (!regs_ff[R_VWRITE+2][7]) begin
                                 vnext = vaddr_in + 19'd1;
                                 regs_in[R_VWRITE]   = vnext[7:0];
                                 regs_in[R_VWRITE+1] = vnext[15:8];
                                 regs_in[R_VWRITE+2] = {regs_ff[R_VWRITE+2][7], 4'b0,
                                                        vnext[18:16]};
                              end
                           end
                        end
                        PORT_PAL: begin
                           pal_wr.en   = 1'b1;
                           pal_wr.addr = srm_ff ? 8'h00 : regs_ff[R_PALPTR];
                           pal_wr.data = wval & COMP_MASK[pal_wr.addr[1:0]];
                           if (!srm_ff) begin
                              regs_in[R_PALPTR] = pptr;
                           end
                        end
                        PORT_CMD: begin
                           cacc_in  = CACC_WDATA;
                           odata_in = wd_ff;
                        end
                        PORT_REGDAT: begin
                           if (ACC_TAB[ridx][1]) begin
                              if (ridx[5]) begin
                                 cacc_in  = CACC_PARAM;
                                 creg_in  = ridx;
                                 odata_in = wval;
                              end else begin
                                 regs_in[ridx[4:0]] = wval & WMASK_TAB[ridx[4:0]];
                              end
                           end
                           if (!sel_ff[7]) begin
                              sel_in = {sel_ff[7:6], sel_ff[5:0] + 6'd1};
                           end
                        end
                        PORT_REGSEL: begin
                           sel_in = wval;
                        end
                        PORT_IRQ: begin
                           pend_in = pend_ff & ~wd_ff;
                        end
                        PORT_SYSCTL: begin
                           eo_ov_in = wd_ff[0];
                           if (wd_ff[1] != srm_ff) begin
                              srm_in = wd_ff[1];
                              if (wd_ff[1]) begin
                                 for (int i = 0; i < NUM_REGS; i++) begin
                                    if (ACC_TAB[i][1]) begin
                                       regs_in[i] = 8'h00;
                                    end
                                 end
                                 cacc_in = CACC_CLEAR;
                                 pend_in = 8'h00;
                              end
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  OP_RAISE: begin
                     pend_in = pend_ff | wd_ff;
                  end
                  default: begin
                  end
               endcase
               irq_in = |(pend_in & regs_in[R_IMASK]);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 8'hFF;
         pend_ff      <= 8'h00;
         eo_ov_ff     <= 1'b0;
         srm_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         pend_ff      <= pend_in;
         eo_ov_ff     <= eo_ov_in;
         srm_ff       <= srm_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         port_ff <= req_port;
         wd_ff   <= req_wdata;
         vrd_ff  <= req_vram_rdata;
         crd_ff  <= req_cmd_rdata;
         cst_ff  <= req_cmd_status;
         hb_ff   <= req_in_hborder;
         vb_ff   <= req_in_vborder;
         bx_ff   <= req_border_x;
      end
      rdata_ff <= rdata_in;
      vaddr_ff <= vaddr_in;
      vacc_ff  <= vacc_in;
      cacc_ff  <= cacc_in;
      creg_ff  <= creg_in;
      odata_ff <= odata_in;
      irq_ff   <= irq_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rdata       = rdata_ff;
   assign rsp_vram_addr   = vaddr_ff;
   assign rsp_vram_access = vacc_ff;
   assign rsp_cmd_access  = cacc_ff;
   assign rsp_cmd_reg     = creg_ff;
   assign rsp_out_data    = odata_ff;
   assign rsp_irq_line    = irq_ff;

`ifndef SYNTHESIS
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("response without execute cycle");
   a_no_vaddr_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && vacc_ff == VACC_NONE |-> vaddr_ff == '0)
      else $error("address without VRAM access");
   a_srm_no_vwrite: assert property (@(posedge clock) disable iff (reset)
      srm_ff && rsp_valid_ff |-> vacc_ff != VACC_WRITE)
      else $error("VRAM write in system reset");
   a_creg_param: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cacc_ff != CACC_PARAM |-> creg_ff == '0)
      else $error("register index without parameter write");
`endif

endmodule

// ===== tb/vcp_checker.sv =====
module vcp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_port,
   input  logic [7:0]  req_wdata,
   input  logic [7:0]  req_vram_rdata,
   input  logic [7:0]  req_cmd_rdata,
   input  logic [7:0]  req_cmd_status,
   input  logic        req_in_hborder,
   input  logic        req_in_vborder,
   input  logic [15:0] req_border_x,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_rdata,
   input  logic [18:0] rsp_vram_addr,
   input  logic [1:0]  rsp_vram_access,
   input  logic [2:0]  rsp_cmd_access,
   input  logic [5:0]  rsp_cmd_reg,
   input  logic [7:0]  rsp_out_data,
   input  logic        rsp_irq_line,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import vcp_pkg::*;

   typedef struct packed {
      logic [7:0]  rdata;
      logic [18:0] vaddr;
      logic [1:0]  vacc;
      logic [2:0]  cacc;
      logic [5:0]  creg;
      logic [7:0]  odata;
      logic        irq;
   } port_result_type;

   logic [7:0] ctl [NUM_REGS];
   logic [7:0] pal [PAL_DEPTH];
   logic [7:0] sel;
   logic [7:0] flags;
   logic [7:0] stat;
   logic       sysrst;
   port_result_type want_q[$];
   port_result_type cur;

   assign pending_count = want_q.size();

   function automatic logic [18:0] addr_of(int unsigned b);
      return {ctl[b+2][2:0], ctl[b+1], ctl[b]};
   endfunction

   task automatic addr_bump(int unsigned b);
      logic [18:0] a;
      a = addr_of(b) + 19'd1;
      ctl[b] = a[7:0];
      ctl[b+1] = a[15:8];
      ctl[b+2] = {ctl[b+2][7], 4'd0, a[18:16]};
   endtask

   task automatic pal_advance();
      logic [7:0] p;
      p = ctl[R_PALPTR];
      case (p[1:0])
         2'd0, 2'd1: p = p + 8'd1;
         2'd2: p = p + 8'd2;
         default: p = p - 8'd3;
      endcase
      ctl[R_PALPTR] = p;
   endtask

   task automatic register_write(logic [7:0] r8, logic [7:0] v, inout port_result_type o);
      logic [5:0] r;
      r = r8[5:0];
      if (!ACC_TAB[r][1]) return;
      if (r >= 6'd32) begin
         o.cacc = CACC_PARAM;
         o.creg = r;
         o.odata = v;
         return;
      end
      ctl[r[4:0]] = v & WMASK_TAB[r[4:0]];
   endtask

   function automatic logic [7:0] register_read(logic [7:0] r8, logic [15:0] bx);
      logic [5:0] r;
      r = r8[5:0];
      if (sysrst || !ACC_TAB[r][0]) return 8'hFF;
      if (r == R_BORDER_LO) return bx[7:0];
      if (r == R_BORDER_HI) return bx[15:8];
      return ctl[r[4:0]];
   endfunction

   task automatic predict_access();
      port_result_type o;
      o = '0;
      if (req_opcode == OP_READ) begin
         o.rdata = 8'hFF;
         case (req_port)
            PORT_VRAM: begin
               o.vaddr = addr_of(R_VREAD);
               o.vacc = VACC_READ;
               o.rdata = req_vram_rdata;
               if (!sysrst && !ctl[R_VREAD+2][7]) addr_bump(R_VREAD);
            end
            PORT_PAL: begin
               o.rdata = pal[ctl[R_PALPTR]];
               if (!sysrst && !ctl[R_PALCTL][4]) pal_advance();
            end
            PORT_CMD: begin
               o.rdata = req_cmd_rdata;
               o.cacc = CACC_RDATA;
            end
            PORT_REGDAT: begin
               o.rdata = register_read(sel, req_border_x);
               if (!sysrst && !sel[6]) sel = (sel + 8'd1) & 8'hBF;
            end
            PORT_STATUS: o.rdata = req_cmd_status | {1'b0, req_in_vborder, req_in_hborder,
                                   5'd0} | (stat & 8'h06);
            PORT_IRQ: o.rdata = flags;
            default: ;
         endcase
      end else if (req_opcode == OP_WRITE) begin
         case (req_port)
            PORT_VRAM: if (!sysrst) begin
               o.vaddr = addr_of(R_VWRITE);
               o.vacc = VACC_WRITE;
               o.odata = req_wdata;
               if (!ctl[R_VWRITE+2][7]) addr_bump(R_VWRITE);
            end
            PORT_PAL: begin
               if (sysrst) pal[0] = 8'h00;
               else begin
                  pal[ctl[R_PALPTR]] = req_wdata & COMP_MASK[ctl[R_PALPTR][1:0]];
                  pal_advance();
               end
            end
            PORT_CMD: begin
               o.cacc = CACC_WDATA;
               o.odata = req_wdata;
            end
            PORT_REGDAT: begin
               register_write(sel, sysrst ? 8'h00 : req_wdata, o);
               if (!sel[7]) sel = {sel[7:6], sel[5:0] + 6'd1};
            end
            PORT_REGSEL: sel = sysrst ? 8'h00 : req_wdata;
            PORT_IRQ: flags = flags & ~req_wdata;
            PORT_SYSCTL: begin
               stat = {stat[7:3], req_wdata[0], stat[1:0]};
               if (req_wdata[1] != sysrst) begin
                  sysrst = req_wdata[1];
                  if (sysrst) begin
                     for (int i = 0; i < NUM_REGS; i++)
                        if (ACC_TAB[i][1]) ctl[i] = 8'h00;
                     o.cacc = CACC_CLEAR;
                     flags = 8'h00;
                  end
               end
            end
            default: ;
         endcase
      end else if (req_opcode == OP_RAISE) begin
         flags = flags | req_wdata;
      end
      o.irq = (flags & ctl[R_IMASK]) != 8'h00;
      want_q.push_back(o);
   endtask

   task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) ctl[i] = 8'h00;
         for (int i = 0; i < PAL_DEPTH; i++) pal[i] = COMP_MASK[i % 4];
         sel = 8'hFF;
         flags = 8'h00;
         stat = 8'h00;
         sysrst = 1'b0;
         want_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) predict_access();
         if (rsp_valid && rsp_ready) begin
            if (want_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               cur = want_q.pop_front();
               cmp("rdata", 32'(cur.rdata), 32'(rsp_rdata));
               cmp("vram_addr", 32'(cur.vaddr), 32'(rsp_vram_addr));
               cmp("vram_access", 32'(cur.vacc), 32'(rsp_vram_access));
               cmp("cmd_access", 32'(cur.cacc), 32'(rsp_cmd_access));
               cmp("cmd_reg", 32'(cur.creg), 32'(rsp_cmd_reg));
               cmp("out_data", 32'(cur.odata), 32'(rsp_out_data));
               cmp("irq_line", 32'(cur.irq), 32'(rsp_irq_line));
            end
         end
      end
   end
endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import vcp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_port = '0;
   logic [7:0]  req_wdata = '0;
   logic [7:0]  req_vram_rdata = '0;
   logic [7:0]  req_cmd_rdata = '0;
   logic [7:0]  req_cmd_status = '0;
   logic        req_in_hborder = 1'b0;
   logic        req_in_vborder = 1'b0;
   logic [15:0] req_border_x = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_rdata;
   logic [18:0] rsp_vram_addr;
   logic [1:0]  rsp_vram_access;
   logic [2:0]  rsp_cmd_access;
   logic [5:0]  rsp_cmd_reg;
   logic [7:0]  rsp_out_data;
   logic        rsp_irq_line;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          stim_done = 1'b0;
   bit          hold_off = 1'b0;

   video_chip_port_register_file_core u_top (.*);
   vcp_checker u_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: own stall pattern, plus one long hold-off
   initial begin
      int phase;
      phase = 0;
      @(posedge clock iff !reset);
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_ready <= 1'b0;
         else if ((phase / 64) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_request(logic [1:0] op, logic [3:0] prt, logic [7:0] wd);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_port <= prt;
      req_wdata <= wd;
      req_vram_rdata <= 8'($urandom);
      req_cmd_rdata <= 8'($urandom);
      req_cmd_status <= 8'($urandom);
      req_in_hborder <= 1'($urandom);
      req_in_vborder <= 1'($urandom);
      req_border_x <= 16'($urandom);
      @(posedge clock iff req_ready);
   endtask

   task automatic send_random();
      int k;
      logic [1:0] op;
      logic [3:0] prt;
      logic [7:0] wd;
      k = $urandom_range(0, 99);
      wd = 8'($urandom);
      prt = 4'($urandom_range(0, 7));
      if (k < 45) op = OP_WRITE;
      else if (k < 85) op = OP_READ;
      else if (k < 93) op = OP_RAISE;
      else begin
         op = 2'($urandom);
         prt = 4'($urandom);
      end
      if (op == OP_WRITE && prt == PORT_SYSCTL && $urandom_range(0, 3) != 0)
         wd[1] = 1'b0;
      if (op == OP_WRITE && prt == PORT_REGSEL && $urandom_range(0, 1))
         wd = {wd[7:6], 6'($urandom_range(0, 20))};
      send_request(op, prt, wd);
   endtask

   initial begin
      int gap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send_request(OP_READ, PORT_REGDAT, 8'h00);
      send_request(OP_WRITE, PORT_REGSEL, 8'h09);
      send_request(OP_WRITE, PORT_REGDAT, 8'hFF);
      send_request(OP_RAISE, PORT_VRAM, 8'hFF);
      send_request(OP_READ, PORT_IRQ, 8'h00);
      send_request(OP_WRITE, PORT_IRQ, 8'h0F);
      send_request(OP_WRITE, PORT_REGSEL, 8'h00);
      send_request(OP_WRITE, PORT_REGDAT, 8'hFF);
      send_request(OP_WRITE, PORT_REGDAT, 8'hFF);
      send_request(OP_WRITE, PORT_REGDAT, 8'h87);
      send_request(OP_WRITE, PORT_VRAM, 8'hA5);
      send_request(OP_WRITE, PORT_REGSEL, 8'h20);
      send_request(OP_WRITE, PORT_REGDAT, 8'h5A);
      send_request(OP_WRITE, PORT_REGSEL, 8'h35);
      send_request(OP_READ, PORT_REGDAT, 8'h00);
      send_request(OP_READ, PORT_REGDAT, 8'h00);
      send_request(OP_WRITE, PORT_PAL, 8'hFF);
      send_request(OP_READ, PORT_PAL, 8'h00);
      send_request(OP_READ, PORT_VRAM, 8'h00);
      send_request(OP_READ, PORT_STATUS, 8'h00);
      send_request(OP_WRITE, PORT_SYSCTL, 8'h03);
      send_request(OP_WRITE, PORT_PAL, 8'h33);
      send_request(OP_READ, PORT_REGDAT, 8'h00);
      send_request(OP_WRITE, PORT_SYSCTL, 8'h00);
      send_request(OP_NOP, 4'd15, 8'hFF);
      // random, in bursts
      for (int n = 0; n < 1000; ) begin
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         for (int b = $urandom_range(1, 20); b > 0 && n < 1000; b--, n++) begin
            if (n == 500) hold_off = 1'b1;
            send_random();
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      @(posedge clock iff hold_off);
      repeat (200) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      @(posedge clock iff (stim_done && pending_count == 0));
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/vcp_pkg.sv
design/vcp_palette_ram.sv
design/video_chip_port_register_file_core.sv
tb/vcp_checker.sv
tb/testbench.sv
